FILE: hw/rtl/modular_inverse_ext_euclid_assert.svh
// Assertion macros for the modular inverse block.
// No dependencies.
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MIE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hw/rtl/mie_pkg.sv
// Shared types and constants for the modular inverse block.
// No dependencies.
package mie_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   typedef struct packed {
      logic [DATA_WIDTH_DEF-1:0] modulus;
      logic signed [DATA_WIDTH_DEF-1:0] operand;
   } req_type;
   typedef struct packed {
      logic                      status;
      logic [DATA_WIDTH_DEF-1:0] additive_inverse;
      logic [DATA_WIDTH_DEF-1:0] multiplicative_inverse;
   } rsp_type;
   typedef enum logic [2:0] {
      OP_LOAD, OP_REDUCE_START, OP_REDUCE_FIX, OP_DIV_START, OP_STEP, OP_MUL_START,
      OP_UPDATE, OP_FINAL_START
   } op_type;
   typedef struct packed {
      logic  valid;
      op_type op;
   } cmd_type;
   typedef struct packed {
      logic unit_done;
      logic m_small;
      logic r1_zero;
      logic r1_one;
   } stat_type;
endpackage

FILE: hw/rtl/modular_inverse_ext_euclid.sv
// Top level of the modular inverse block (extended Euclid).
// Depends on mie_pkg, mie_control and mie_datapath.
//
//  channel | ports                   | transfer when
//  req     | start, busy, req_data   | start high and busy low
//  rsp     | rsp_valid, rsp_data     | rsp_valid high (one cycle, no stall)
//
// Sequence: the check and the operand reduction, then per Euclid step the test,
// divider, multiplier and update, then the final reduction before the strobe.
// Reset clears the controller and the divider busy flag; the payload needs none.
// Busy drops in the strobe cycle, so the next transfer may be taken at its end.
module modular_inverse_ext_euclid import mie_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   cmd_type  cmd;
   stat_type stat;
   logic     done, fail;
   logic [DATA_WIDTH-1:0] add_inv, mul_inv;

   // sequence one item at a time through the shared units
   mie_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .busy(busy), .cmd(cmd), .done(done), .fail(fail)
   );

   // hold operands, remainders and coefficients
   mie_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_modulus(DATA_WIDTH'(req_data.modulus)),
      .in_operand(DATA_WIDTH'(req_data.operand)),
      .stat(stat), .add_inv(add_inv), .mul_inv(mul_inv)
   );

   // drop the inverse fields to zero on failure
   assign rsp_valid = done;
   assign rsp_data.status = fail;
   assign rsp_data.additive_inverse = fail ? '0 : DATA_WIDTH_DEF'(add_inv);
   assign rsp_data.multiplicative_inverse = fail ? '0 : DATA_WIDTH_DEF'(mul_inv);
endmodule

FILE: hw/rtl/mie_datapath.sv
// Datapath: remainders, coefficients, shared restoring divider and
// shift-add multiplier. Depends on mie_pkg.
module mie_datapath import mie_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] in_modulus,
   input  logic [DATA_WIDTH-1:0] in_operand,
   output stat_type              stat,
   output logic [DATA_WIDTH-1:0] add_inv,
   output logic [DATA_WIDTH-1:0] mul_inv
);
   localparam int W = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] m_ff, raw_ff, y_ff, r0_ff, r1_ff, t0_ff, t1_ff;
   logic         neg_ff, t1neg_ff;
   // shared divider: num / den
   logic [W-1:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [CW-1:0] cnt_ff;
   logic         busy_ff, is_mul_ff;
   // multiplier accumulator q*t1 (coefficients stay below modulus)
   logic [W-1:0] acc_ff, mcand_ff, mplier_ff;
   logic [W:0]   trial;
   logic [W-1:0] rsh;
   logic [W-1:0] mag;
   logic [W-1:0] fr;

   assign rsh   = {rem_ff[W-2:0], num_ff[W-1]};
   assign trial = {rem_ff[W-1], rsh} - {1'b0, den_ff};
   assign mag   = W'(~raw_ff + W'(1));
   assign fr    = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.valid) begin
         case (cmd.op)
            OP_LOAD: begin
               m_ff <= in_modulus;
               raw_ff <= in_operand;
               neg_ff <= in_operand[W-1];
            end
            OP_REDUCE_START: begin
               num_ff <= neg_ff ? mag : raw_ff;
               den_ff <= m_ff;
               rem_ff <= '0;
               cnt_ff <= CW'(W);
               is_mul_ff <= 1'b0;
               busy_ff <= 1'b1;
            end
            OP_REDUCE_FIX: begin
               y_ff  <= (neg_ff && fr != '0) ? m_ff - fr : fr;
               r0_ff <= m_ff;
               r1_ff <= (neg_ff && fr != '0) ? m_ff - fr : fr;
               t0_ff <= '0;
               t1_ff <= W'(1);
               t1neg_ff <= 1'b0;
            end
            OP_DIV_START: begin
               num_ff <= r0_ff;
               den_ff <= r1_ff;
               rem_ff <= '0;
               cnt_ff <= CW'(W);
               is_mul_ff <= 1'b0;
               busy_ff <= 1'b1;
            end
            OP_MUL_START: begin
               acc_ff <= '0;
               mcand_ff <= t1_ff;
               mplier_ff <= quo_ff;
               cnt_ff <= CW'(W);
               is_mul_ff <= 1'b1;
               busy_ff <= 1'b1;
            end
            OP_UPDATE: begin
               r0_ff <= r1_ff;
               r1_ff <= rem_ff;
               t0_ff <= t1_ff;
               t1_ff <= t0_ff + acc_ff;
               t1neg_ff <= ~t1neg_ff;
            end
            OP_FINAL_START: begin
               num_ff <= t1_ff;
               den_ff <= m_ff;
               rem_ff <= '0;
               cnt_ff <= CW'(W);
               is_mul_ff <= 1'b0;
               busy_ff <= 1'b1;
            end
            default: begin
               busy_ff <= busy_ff;
            end
         endcase
      end else if (busy_ff) begin
         if (is_mul_ff) begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= {mcand_ff[W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[W-1:1]};
         end else begin
            num_ff <= {num_ff[W-2:0], 1'b0};
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= rsh;
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
         end
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) busy_ff <= 1'b0;
      end
   end

   assign stat.unit_done = ~busy_ff;
   assign stat.m_small   = (m_ff[W-1:1] == '0);
   assign stat.r1_zero   = (r1_ff == '0);
   assign stat.r1_one    = (r1_ff == W'(1));
   assign add_inv = m_ff - y_ff;
   assign mul_inv = (t1neg_ff && fr != '0) ? m_ff - fr : fr;
endmodule

FILE: hw/rtl/mie_control.sv
// Controller state machine sequencing the datapath.
// Depends on mie_pkg.
module mie_control import mie_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd,
   output logic     done,
   output logic     fail
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RED, S_RED_WAIT, S_RED_FIX, S_TEST, S_DIV_WAIT, S_MUL,
      S_MUL_WAIT, S_UPD, S_FIN_WAIT, S_OUT
   } state_type;
   state_type state_ff;
   logic done_ff, fail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE:     if (start) state_ff <= S_CHECK;
            S_CHECK: begin
               if (stat.m_small) begin
                  fail_ff <= 1'b1; done_ff <= 1'b1; state_ff <= S_IDLE;
               end else state_ff <= S_RED;
            end
            S_RED:      state_ff <= S_RED_WAIT;
            S_RED_WAIT: if (stat.unit_done) state_ff <= S_RED_FIX;
            S_RED_FIX:  state_ff <= S_TEST;
            S_TEST: begin
               if (stat.r1_zero) begin
                  fail_ff <= 1'b1; done_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (stat.r1_one) state_ff <= S_FIN_WAIT;
               else state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: if (stat.unit_done) state_ff <= S_MUL;
            S_MUL:      state_ff <= S_MUL_WAIT;
            S_MUL_WAIT: if (stat.unit_done) state_ff <= S_UPD;
            S_UPD:      state_ff <= S_TEST;
            S_FIN_WAIT: if (stat.unit_done) state_ff <= S_OUT;
            S_OUT: begin
               fail_ff <= 1'b0; done_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // one-cycle datapath commands decoded from state and transition
   always_comb begin
      cmd.valid = 1'b0;
      cmd.op    = OP_LOAD;
      case (state_ff)
         S_IDLE:    begin cmd.valid = start; cmd.op = OP_LOAD; end
         S_RED:     begin cmd.valid = 1'b1; cmd.op = OP_REDUCE_START; end
         S_RED_FIX: begin cmd.valid = 1'b1; cmd.op = OP_REDUCE_FIX; end
         S_TEST: begin
            cmd.valid = !stat.r1_zero;
            cmd.op    = stat.r1_one ? OP_FINAL_START : OP_DIV_START;
         end
         S_MUL:     begin cmd.valid = 1'b1; cmd.op = OP_MUL_START; end
         S_UPD:     begin cmd.valid = 1'b1; cmd.op = OP_UPDATE; end
         default:   cmd.valid = 1'b0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign fail = fail_ff;
endmodule

FILE: hw/rtl/mie_checker.sv
// Port-level checker for the modular inverse block, bound to the top.
// Depends on mie_pkg and the assertion macro header.
`include "modular_inverse_ext_euclid_assert.svh"
module mie_checker import mie_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   logic rsp_zero;

   assign rsp_zero = (rsp_data.additive_inverse == '0) &&
                     (rsp_data.multiplicative_inverse == '0);

   `MIE_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `MIE_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid)
   `MIE_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && rsp_data.status, rsp_zero)
   `MIE_ASSERT_IMPL(a_idle_quiet, clock, reset, !busy && !$past(busy), !rsp_valid)
endmodule

bind modular_inverse_ext_euclid mie_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

FILE: test/tb_modular_inverse_ext_euclid.sv
// Testbench for modular_inverse_ext_euclid: directed and random modulus/operand pairs
// are compared against a behavioral extended Euclid inverse predictor.
// Depends on mie_pkg and the modular_inverse_ext_euclid RTL.
module tb_modular_inverse_ext_euclid;
   import mie_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 10000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type inverse_due[$];
   int      mismatch_cnt = 0;
   int      cycle_cnt = 0;
   int      idle_pct = 6;
   bit      hold_off = 1'b0;
   bit      all_loaded = 1'b0;

   modular_inverse_ext_euclid dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Compute the expected status and both inverses for one request.
   function automatic rsp_type predict_inverse(req_type r);
      rsp_type     res;
      logic [63:0] m, y, mag, rem, r0, r1, t0, t1, q, nr, nt;
      bit          t1neg;
      res = '0;
      res.status = 1'b1;
      m = {32'b0, r.modulus};
      if (m <= 1) return res;
      if (r.operand[31]) begin
         mag = {32'b0, (~r.operand + 32'd1)};
         rem = mag % m;
         y = (rem == 0) ? 64'd0 : m - rem;
      end else begin
         y = {32'b0, r.operand} % m;
      end
      if (y == 0) return res;
      r0 = m; r1 = y; t0 = 0; t1 = 1; t1neg = 1'b0;
      while (r1 != 1) begin
         if (r1 == 0) return res;
         q = r0 / r1;
         nr = r0 - q * r1;
         nt = t0 + q * t1;
         r0 = r1; r1 = nr; t0 = t1; t1 = nt;
         t1neg = ~t1neg;
      end
      res.status = 1'b0;
      res.additive_inverse = 32'(m - y);
      res.multiplicative_inverse = t1neg ? 32'((m - (t1 % m)) % m) : 32'(t1 % m);
      return res;
   endfunction

   // Driver: present a transfer at the falling edge only while busy is low, so it
   // is taken at the next rising edge; drop start once busy is high.
   always @(negedge clock) begin
      if (reset || busy) begin
         start <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
         req_data <= pending_ops.pop_front();
         start <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // Record the expectation when a transfer is accepted.
   always @(posedge clock) begin
      if (!reset && start && !busy) inverse_due.push_back(predict_inverse(req_data));
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (inverse_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            exp_rsp = inverse_due.pop_front();
            if (exp_rsp.status !== rsp_data.status ||
                exp_rsp.additive_inverse !== rsp_data.additive_inverse ||
                exp_rsp.multiplicative_inverse !== rsp_data.multiplicative_inverse) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: exp st=%0d add=%h mul=%h got st=%0d add=%h mul=%h",
                     exp_rsp.status, exp_rsp.additive_inverse,
                     exp_rsp.multiplicative_inverse, rsp_data.status,
                     rsp_data.additive_inverse, rsp_data.multiplicative_inverse);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("tb_modular_inverse_ext_euclid failed");
         $finish;
      end
   end

   task automatic queue_op(logic [31:0] m, logic [31:0] v);
      req_type r;
      r.modulus = m;
      r.operand = v;
      pending_ops.push_back(r);
   endtask

   // Mix small moduli (fast, frequent inverses) with full-width ones.
   task automatic queue_random(int n);
      logic [31:0] m, v;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: m = $urandom_range(257);
            1: m = $urandom_range(65535);
            default: m = $urandom;
         endcase
         case ($urandom_range(3))
            0: v = $urandom_range(511);
            1: v = -$urandom_range(511);
            default: v = $urandom;
         endcase
         queue_op(m, v);
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || start || inverse_due.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Directed: zero modulus, modulus one, multiples, gcd not 1, extremes.
      queue_op(0, 5);
      queue_op(1, 7);
      queue_op(2, 1);
      queue_op(7, 14);
      queue_op(7, -14);
      queue_op(12, 8);
      queue_op(11, 3);
      queue_op(11, -3);
      queue_op(11, 100);
      queue_op(32'hFFFFFFFF, 32'h7FFFFFFF);
      queue_op(32'hFFFFFFFF, 32'h80000000);
      queue_op(32'hFFFFFFFB, 32'hFFFFFFFF);
      queue_op(32'h80000000, 32'h80000000);
      queue_op(32'h80000001, 32'h7FFFFFFF);
      queue_op(2, 32'hFFFFFFFF);
      queue_op(32'hFFFFFFFE, 3);
      queue_op(3, 0);
      queue_op(32'h55555555, 32'hAAAAAAAB);
      queue_random(130);
      wait_drained();
      // Pause with every expected result in, then raise the driver's idle share.
      hold_off = 1'b1;
      repeat (20) @(posedge clock);
      hold_off = 1'b0;
      idle_pct = 70;
      queue_random(130);
      wait_drained();
      idle_pct = 0;
      queue_random(130);
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatch_cnt == 0 && inverse_due.size() == 0)
         $display("tb_modular_inverse_ext_euclid passed");
      else
         $display("tb_modular_inverse_ext_euclid failed");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mie_pkg.sv
hw/rtl/mie_datapath.sv
hw/rtl/mie_control.sv
hw/rtl/modular_inverse_ext_euclid.sv
hw/rtl/mie_checker.sv
test/tb_modular_inverse_ext_euclid.sv
